[hdl/ssgr_pkg.sv]
// ----------------------------------------------------------------------------
// ssgr_pkg
// Types, constants and codes shared by the grid resampler modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ssgr_pkg;

  localparam int unsigned MaxSignals       = 16;
  localparam int unsigned SamplesPerSignal = 256;
  localparam int unsigned SigW   = 4;
  localparam int unsigned CntW   = 9;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned AddrW  = SigW + SlotW;
  localparam int unsigned Depth  = MaxSignals * SamplesPerSignal;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ROW  = 2'd0,
    ST_ACK  = 2'd1,
    ST_FULL = 2'd2,
    ST_END  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_SPAN   = 2'd1,
    REG_STEP   = 2'd2,
    REG_SIGNUM = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RESTART,
    BK_READ,
    BK_WAIT,
    BK_CHECK,
    BK_EMIT
  } back_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         sig_idx;
    logic [31:0]        sample_time;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        row_index;
    logic [3:0]         out_signal;
    logic signed [31:0] held_value;
    logic               last_of_row;
  } out_item_t;

  // Classified work handed from front to back.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  sig;
    logic        dropped;
  } cmd_t;

endpackage
`default_nettype wire

[hdl/ssgr_ram.sv]
// ----------------------------------------------------------------------------
// ssgr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ssgr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/ssgr_front.sv]
// ----------------------------------------------------------------------------
// ssgr_front
// Accepts items, writes loaded samples to the stores, tracks fill counts and
// passes classified commands through a two-entry queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ssgr_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  ssgr_pkg::in_item_t        item_i,
  output logic                      full_o,
  output logic                      we_o,
  output logic [ssgr_pkg::AddrW-1:0] waddr_o,
  output ssgr_pkg::cmd_t            cmd_o,
  output logic                      cmd_valid_o,
  input  wire logic                 cmd_pop_i
);
  import ssgr_pkg::*;

  logic [CntW-1:0] fill_q [MaxSignals];
  cmd_t            fifo_q [2];
  logic            rd_q, wr_q;
  logic [1:0]      cnt_q;
  logic            acc;
  logic            drop;
  cmd_t            cmd;

  assign full_o      = cnt_q == 2'd2;
  assign acc         = push_i && !full_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = fifo_q[rd_q];
  assign drop        = fill_q[item_i.sig_idx] >= CntW'(SamplesPerSignal);
  assign we_o        = acc && item_i.opcode == OP_LOAD && !drop;
  assign waddr_o     = {item_i.sig_idx,
                        fill_q[item_i.sig_idx][SlotW-1:0]};

  always_comb begin
    cmd.opcode  = item_i.opcode;
    cmd.sig     = item_i.sig_idx;
    cmd.dropped = drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
      for (int i = 0; i < MaxSignals; i++) fill_q[i] <= '0;
    end else begin
      if (we_o) begin
        fill_q[item_i.sig_idx] <= fill_q[item_i.sig_idx] + 1'b1;
      end
      if (acc && item_i.opcode != OP_NONE) begin
        fifo_q[wr_q] <= cmd;
        wr_q         <= ~wr_q;
      end
      if (cmd_pop_i && cmd_valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, acc && item_i.opcode != OP_NONE}
                     - {1'b0, cmd_pop_i && cmd_valid_o};
    end
  end
endmodule
`default_nettype wire

[hdl/ssgr_back.sv]
// ----------------------------------------------------------------------------
// ssgr_back
// Carries out commands: merges pending samples per signal up to the grid
// time, holds values, and emits rows, acknowledgments and end markers into an output queue.
// ----------------------------------------------------------------------------
`default_nettype none
module ssgr_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  ssgr_pkg::cmd_t             cmd_i,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_pop_o,
  output logic [ssgr_pkg::AddrW-1:0] raddr_o,
  input  wire logic [31:0]           rtime_i,
  input  wire logic [31:0]           rvalue_i,
  input  wire logic [31:0]           start_time_i,
  input  wire logic [31:0]           span_i,
  input  wire logic [15:0]           step_i,
  input  wire logic [4:0]            signum_i,
  output ssgr_pkg::out_item_t        out_o,
  output logic                       empty_o,
  input  wire logic                  pop_i
);
  import ssgr_pkg::*;

  back_e             state_q, state_d;
  logic [CntW-1:0]   cur_q [MaxSignals];
  logic [CntW-1:0]   fill_q [MaxSignals];
  logic [31:0]       held_q [MaxSignals];
  logic [32:0]       grid_q;
  logic [15:0]       row_q;
  logic [SigW-1:0]   sig_q;
  out_item_t         oq_q;
  logic              ov_q;
  logic [32:0]       end_t, grid_nx;
  logic [SigW-1:0]   last_sig;
  logic [CntW-1:0]   fill_s;
  logic              oq_free;
  logic [15:0]       step_e;
  logic              take;
  logic              beat_v;
  out_item_t         beat_d;

  assign end_t    = {1'b0, start_time_i} + {1'b0, span_i};
  assign step_e   = (step_i == '0) ? 16'd1 : step_i;
  assign grid_nx  = grid_q + {17'd0, step_e};
  assign last_sig = (signum_i == '0) ? '0 :
                    (signum_i > 5'(MaxSignals)) ? SigW'(MaxSignals - 1) :
                    SigW'(signum_i - 5'd1);
  assign fill_s   = fill_q[sig_q];
  assign raddr_o  = {sig_q, cur_q[sig_q][SlotW-1:0]};
  assign oq_free  = !ov_q || pop_i;
  assign empty_o  = !ov_q;
  assign out_o    = oq_q;
  assign take     = state_q == BK_CHECK && cur_q[sig_q] < fill_s &&
                    {1'b0, rtime_i} <= grid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    beat_v    = 1'b0;
    beat_d    = '0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && oq_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.opcode)
            OP_LOAD: begin
              beat_v            = 1'b1;
              beat_d.status     = cmd_i.dropped ? ST_FULL : ST_ACK;
              beat_d.out_signal = cmd_i.sig;
            end
            OP_RESTART: begin
              beat_v        = 1'b1;
              beat_d.status = ST_ACK;
            end
            OP_ADVANCE: begin
              if (grid_q >= end_t) begin
                beat_v        = 1'b1;
                beat_d.status = ST_END;
              end else begin
                state_d = BK_READ;
              end
            end
            default: ;
          endcase
        end
      end
      BK_READ:  state_d = (cur_q[sig_q] < fill_s) ? BK_WAIT : BK_CHECK;
      BK_WAIT:  state_d = BK_CHECK;
      BK_CHECK: begin
        if (take) begin
          state_d = BK_READ;
        end else if (sig_q == SigW'(MaxSignals - 1)) begin
          state_d = BK_EMIT;
        end else begin
          state_d = BK_READ;
        end
      end
      BK_EMIT: begin
        if (oq_free) begin
          beat_v             = 1'b1;
          beat_d.status      = ST_ROW;
          beat_d.row_index   = row_q;
          beat_d.out_signal  = sig_q;
          beat_d.held_value  = held_q[sig_q];
          beat_d.last_of_row = sig_q == last_sig;
          if (sig_q == last_sig) state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      oq_q   <= '0;
      grid_q <= '0;
      row_q  <= '0;
      sig_q  <= '0;
      for (int i = 0; i < MaxSignals; i++) begin
        cur_q[i]  <= '0;
        fill_q[i] <= '0;
        held_q[i] <= '0;
      end
    end else begin
      ov_q <= beat_v || (ov_q && !pop_i);
      if (beat_v) oq_q <= beat_d;
      case (state_q)
        BK_IDLE: begin
          sig_q <= '0;
          if (cmd_pop_o) begin
            if (cmd_i.opcode == OP_LOAD && !cmd_i.dropped) begin
              fill_q[cmd_i.sig] <= fill_q[cmd_i.sig] + 1'b1;
            end
            if (cmd_i.opcode == OP_RESTART) begin
              grid_q <= {1'b0, start_time_i};
              row_q  <= '0;
              for (int i = 0; i < MaxSignals; i++) begin
                cur_q[i]  <= '0;
                held_q[i] <= '0;
              end
            end
          end
        end
        BK_CHECK: begin
          if (take) begin
            held_q[sig_q] <= rvalue_i;
            cur_q[sig_q]  <= cur_q[sig_q] + 1'b1;
          end else if (sig_q == SigW'(MaxSignals - 1)) begin
            sig_q <= '0;
          end else begin
            sig_q <= sig_q + 1'b1;
          end
        end
        BK_EMIT: begin
          if (oq_free) begin
            sig_q <= sig_q + 1'b1;
            if (sig_q == last_sig) begin
              grid_q <= (grid_nx > end_t) ? end_t : grid_nx;
              row_q  <= row_q + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/sparse_series_grid_resampler.sv]
// A load or restart result passes through the command queue and then the
// output register. An advance merges pending samples, signal by signal, up to
// the grid time through the store read port, then emits one row value a cycle
// while the output queue has room. Throughput: one item at a time in the back
// end, a two-entry command queue. Reset: asynchronous; fill counts, cursors,
// held row, grid time clear at once.
// ----------------------------------------------------------------------------
// sparse_series_grid_resampler
// Sample-and-hold resampler of sparse per-signal series onto a regular grid.
// ----------------------------------------------------------------------------
`default_nettype none
module sparse_series_grid_resampler (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  ssgr_pkg::in_item_t       in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output ssgr_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);
  import ssgr_pkg::*;

  logic [31:0] start_q, span_q;
  logic [15:0] step_q;
  logic [4:0]  signum_q;
  logic        we, cmd_valid, cmd_pop;
  logic [AddrW-1:0] waddr, raddr;
  cmd_t        cmd;
  logic [31:0] rtime, rvalue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      span_q   <= 32'd1;
      step_q   <= 16'd1;
      signum_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START:  start_q  <= cfg_data_i;
        REG_SPAN:   span_q   <= cfg_data_i;
        REG_STEP:   step_q   <= cfg_data_i[15:0];
        REG_SIGNUM: signum_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  ssgr_front u_front (
    .clk_i, .rst_ni, .push_i(push), .item_i(in_item_i), .full_o(full),
    .we_o(we), .waddr_o(waddr), .cmd_o(cmd), .cmd_valid_o(cmd_valid),
    .cmd_pop_i(cmd_pop)
  );

  ssgr_ram #(.Width(32), .Depth(Depth)) u_time (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(in_item_i.sample_time),
    .raddr_i(raddr), .rdata_o(rtime)
  );

  ssgr_ram #(.Width(32), .Depth(Depth)) u_value (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(in_item_i.sample_value),
    .raddr_i(raddr), .rdata_o(rvalue)
  );

  ssgr_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .raddr_o(raddr), .rtime_i(rtime), .rvalue_i(rvalue),
    .start_time_i(start_q), .span_i(span_q), .step_i(step_q),
    .signum_i(signum_q), .out_o(out_item_o), .empty_o(empty), .pop_i(pop)
  );
endmodule
`default_nettype wire
